// File: src/q8sf_pkg.sv
// ============================================================================
// q8sf_pkg
// Shared types, widths and rounding helpers for the quad8 shape function unit.
// ============================================================================
package q8sf_pkg;

    localparam int FRAC_BITS = 14;
    localparam int COORD_W   = 16;
    localparam int OUT_W     = 16;
    localparam int NODE_W    = 3;

    // Operands: the linear terms (1-x, 2x+y, 1+x+y, ...) and the products ab, cd.
    localparam int OPD_W   = COORD_W + 2;
    localparam int PROD_W  = 2 * OPD_W;
    localparam int FMUL_W  = PROD_W + 1 - FRAC_BITS;
    localparam int PROD2_W = FMUL_W + OPD_W;
    localparam int VAL_W   = PROD2_W + 1 - FRAC_BITS;

    localparam int S_TDATA_W = 2 * COORD_W;
    localparam int M_TDATA_W = 3 * OUT_W;

    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(7);

    localparam logic signed [OPD_W-1:0] ONE_OPD = OPD_W'(2 ** FRAC_BITS);

    typedef enum logic [1:0] {
        SH_NONE,
        SH_HALF,
        SH_QUARTER
    } shift_t;

    typedef struct packed {
        logic   neg;
        shift_t shift;
    } post_op_t;

    // Everything the back end needs to evaluate all eight nodes of one point.
    typedef struct packed {
        logic signed [OPD_W-1:0] x;
        logic signed [OPD_W-1:0] y;
        logic signed [OPD_W-1:0] a;     // 1 - x
        logic signed [OPD_W-1:0] b;     // 1 + x
        logic signed [OPD_W-1:0] c;     // 1 - y
        logic signed [OPD_W-1:0] d;     // 1 + y
        logic signed [OPD_W-1:0] t_pp;  // 1 + x + y
        logic signed [OPD_W-1:0] t_mp;  // 1 - x + y
        logic signed [OPD_W-1:0] t_mm;  // 1 - x - y
        logic signed [OPD_W-1:0] t_pm;  // 1 + x - y
        logic signed [OPD_W-1:0] x2py;  // 2x + y
        logic signed [OPD_W-1:0] x2my;  // 2x - y
        logic signed [OPD_W-1:0] xp2y;  // x + 2y
        logic signed [OPD_W-1:0] y2mx;  // 2y - x
        logic signed [OPD_W-1:0] ab;
        logic signed [OPD_W-1:0] cd;
    } point_t;

    // Product scaled back by 2^FRAC_BITS, rounded to nearest, ties upward.
    function automatic logic signed [FMUL_W-1:0] fmul_round(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W:0] sum;
        sum = (PROD_W + 1)'(p) + $signed((PROD_W + 1)'(2 ** (FRAC_BITS - 1)));
        return FMUL_W'(sum >>> FRAC_BITS);
    endfunction

    function automatic logic signed [VAL_W-1:0] fmul2_round(
        input logic signed [PROD2_W-1:0] p
    );
        logic signed [PROD2_W:0] sum;
        sum = (PROD2_W + 1)'(p) + $signed((PROD2_W + 1)'(2 ** (FRAC_BITS - 1)));
        return VAL_W'(sum >>> FRAC_BITS);
    endfunction

    // Optional negate, final division by 1, 2 or 4 with rounding, then clamp.
    function automatic logic signed [OUT_W-1:0] post_sat(
        input logic signed [VAL_W-1:0] v,
        input post_op_t                op
    );
        logic signed [VAL_W+1:0] w;
        logic signed [VAL_W+1:0] r;
        logic                    fits;
        w = (VAL_W + 2)'(v);
        if (op.neg)
        begin
            w = -w;
        end
        case (op.shift)
            SH_NONE:    r = w;
            SH_HALF:    r = (w + $signed((VAL_W + 2)'(1))) >>> 1;
            SH_QUARTER: r = (w + $signed((VAL_W + 2)'(2))) >>> 2;
            default:    r = w;
        endcase
        fits = (&r[VAL_W+1:OUT_W-1]) || !(|r[VAL_W+1:OUT_W-1]);
        if (fits)
        begin
            return r[OUT_W-1:0];
        end
        else if (r[VAL_W+1])
        begin
            return {1'b1, {(OUT_W - 1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(OUT_W - 1){1'b1}}};
        end
    endfunction

endpackage

// File: src/q8sf_front.sv
// ============================================================================
// q8sf_front
// Takes coordinate beats, forms the linear terms and the products ab and cd.
// ============================================================================
module q8sf_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [q8sf_pkg::S_TDATA_W-1:0]      s_tdata,    // x_coord, y_coord
    output logic                                push_valid,
    input  logic                                push_ready,
    output q8sf_pkg::point_t                    push_data
);

    logic                         pt_valid_reg;
    logic                         pt_valid_next;
    q8sf_pkg::point_t             pt_reg;
    q8sf_pkg::point_t             pt_next;
    logic signed [q8sf_pkg::OPD_W-1:0] xe;
    logic signed [q8sf_pkg::OPD_W-1:0] ye;
    logic signed [q8sf_pkg::FMUL_W-1:0] ab_full;
    logic signed [q8sf_pkg::FMUL_W-1:0] cd_full;
    logic                         accept;

    assign s_tready = !pt_valid_reg || push_ready;
    assign accept   = s_tvalid && s_tready;

    assign xe = q8sf_pkg::OPD_W'($signed(s_tdata[q8sf_pkg::COORD_W-1:0]));
    assign ye = q8sf_pkg::OPD_W'($signed(s_tdata[q8sf_pkg::S_TDATA_W-1:q8sf_pkg::COORD_W]));

    always_comb
    begin
        pt_next      = pt_reg;
        pt_next.x    = xe;
        pt_next.y    = ye;
        pt_next.a    = q8sf_pkg::ONE_OPD - xe;
        pt_next.b    = q8sf_pkg::ONE_OPD + xe;
        pt_next.c    = q8sf_pkg::ONE_OPD - ye;
        pt_next.d    = q8sf_pkg::ONE_OPD + ye;
        pt_next.t_pp = q8sf_pkg::ONE_OPD + xe + ye;
        pt_next.t_mp = q8sf_pkg::ONE_OPD - xe + ye;
        pt_next.t_mm = q8sf_pkg::ONE_OPD - xe - ye;
        pt_next.t_pm = q8sf_pkg::ONE_OPD + xe - ye;
        pt_next.x2py = (xe <<< 1) + ye;
        pt_next.x2my = (xe <<< 1) - ye;
        pt_next.xp2y = xe + (ye <<< 1);
        pt_next.y2mx = (ye <<< 1) - xe;
        pt_next.ab   = '0;
        pt_next.cd   = '0;
    end

    always_comb
    begin
        if (accept)
        begin
            pt_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            pt_valid_next = 1'b0;
        end
        else
        begin
            pt_valid_next = pt_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_valid_reg <= 1'b0;
        end
        else
        begin
            pt_valid_reg <= pt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pt_reg <= pt_next;
        end
    end

    assign ab_full = q8sf_pkg::fmul_round(q8sf_pkg::PROD_W'($signed(pt_reg.a) * $signed(pt_reg.b)));
    assign cd_full = q8sf_pkg::fmul_round(q8sf_pkg::PROD_W'($signed(pt_reg.c) * $signed(pt_reg.d)));

    // ab and cd lie in -3.0 .. 1.0, so they fit an operand word.
    always_comb
    begin
        push_data    = pt_reg;
        push_data.ab = q8sf_pkg::OPD_W'(ab_full);
        push_data.cd = q8sf_pkg::OPD_W'(cd_full);
    end

    assign push_valid = pt_valid_reg;

endmodule

// File: src/q8sf_fifo.sv
// ============================================================================
// q8sf_fifo
// Short point queue between the front end and the node evaluator.
// ============================================================================
module q8sf_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  q8sf_pkg::point_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output q8sf_pkg::point_t  out_data
);

    q8sf_pkg::point_t             entry_reg [q8sf_pkg::QDEPTH];
    logic [q8sf_pkg::QAW-1:0]     wr_ptr_reg;
    logic [q8sf_pkg::QAW-1:0]     wr_ptr_next;
    logic [q8sf_pkg::QAW-1:0]     rd_ptr_reg;
    logic [q8sf_pkg::QAW-1:0]     rd_ptr_next;
    logic [q8sf_pkg::QAW:0]       count_reg;
    logic [q8sf_pkg::QAW:0]       count_next;
    logic                         push;
    logic                         pop;

    assign in_ready  = count_reg != (q8sf_pkg::QAW + 1)'(q8sf_pkg::QDEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: src/q8sf_back.sv
// ============================================================================
// q8sf_back
// Node evaluator: issues the eight nodes of the head point, one per cycle unless
// m_tready stalls, through a two-multiply pipeline into the output register.
// ============================================================================
module q8sf_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    output logic                             q_ready,
    input  q8sf_pkg::point_t                 q_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [q8sf_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [q8sf_pkg::NODE_W-1:0]      m_tuser,
    output logic                             m_tlast
);

    typedef struct packed {
        logic [q8sf_pkg::NODE_W-1:0]       node;
        logic signed [q8sf_pkg::OPD_W-1:0] u1;
        logic signed [q8sf_pkg::OPD_W-1:0] v1;
        logic signed [q8sf_pkg::OPD_W-1:0] u2;
        logic signed [q8sf_pkg::OPD_W-1:0] v2;
        logic signed [q8sf_pkg::OPD_W-1:0] u3;
        logic signed [q8sf_pkg::OPD_W-1:0] v3;
        logic signed [q8sf_pkg::OPD_W-1:0] t;
    } issue_t;

    typedef struct packed {
        logic [q8sf_pkg::NODE_W-1:0]        node;
        logic signed [q8sf_pkg::PROD_W-1:0] p;
        logic signed [q8sf_pkg::PROD_W-1:0] q;
        logic signed [q8sf_pkg::PROD_W-1:0] r;
        logic signed [q8sf_pkg::OPD_W-1:0]  t;
    } prod_t;

    typedef struct packed {
        logic [q8sf_pkg::NODE_W-1:0]         node;
        logic signed [q8sf_pkg::PROD2_W-1:0] pv;
        logic signed [q8sf_pkg::FMUL_W-1:0]  fq;
        logic signed [q8sf_pkg::FMUL_W-1:0]  fr;
    } prod2_t;

    typedef struct packed {
        q8sf_pkg::post_op_t val;
        q8sf_pkg::post_op_t dx;
        q8sf_pkg::post_op_t dy;
    } node_ops_t;

    logic                          en;
    logic                          issue;
    logic [q8sf_pkg::NODE_W-1:0]   node_cnt_reg;
    logic [q8sf_pkg::NODE_W-1:0]   node_cnt_next;
    logic                          s1_valid_reg;
    logic                          s2_valid_reg;
    logic                          s3_valid_reg;
    logic                          out_valid_reg;
    issue_t                        s1_reg;
    issue_t                        s1_next;
    prod_t                         s2_reg;
    prod_t                         s2_next;
    prod2_t                        s3_reg;
    prod2_t                        s3_next;
    logic [q8sf_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [q8sf_pkg::M_TDATA_W-1:0] out_data_next;
    logic [q8sf_pkg::NODE_W-1:0]   out_node_reg;
    node_ops_t                     ops;
    logic signed [q8sf_pkg::VAL_W-1:0] val_v;
    logic signed [q8sf_pkg::VAL_W-1:0] dx_v;
    logic signed [q8sf_pkg::VAL_W-1:0] dy_v;

    // The whole pipeline moves together whenever the output register frees up.
    assign en            = !out_valid_reg || m_tready;
    assign issue         = en && q_valid;
    assign q_ready       = issue && (node_cnt_reg == q8sf_pkg::NODE_LAST);
    assign node_cnt_next = issue ? node_cnt_reg + 1'b1 : node_cnt_reg;

    // Mid-side nodes reuse the second multiplier with a factor of one, and a
    // derivative that is a bare ab or cd goes through a multiply by one as well.
    always_comb
    begin
        s1_next      = '0;
        s1_next.node = node_cnt_reg;
        case (node_cnt_reg)
            3'd0:
            begin
                s1_next.u1 = q_data.a;  s1_next.v1 = q_data.c;
                s1_next.u2 = q_data.c;  s1_next.v2 = q_data.x2py;
                s1_next.u3 = q_data.a;  s1_next.v3 = q_data.xp2y;
                s1_next.t  = q_data.t_pp;
            end
            3'd1:
            begin
                s1_next.u1 = q_data.b;  s1_next.v1 = q_data.c;
                s1_next.u2 = q_data.c;  s1_next.v2 = q_data.x2my;
                s1_next.u3 = q_data.b;  s1_next.v3 = q_data.y2mx;
                s1_next.t  = q_data.t_mp;
            end
            3'd2:
            begin
                s1_next.u1 = q_data.b;  s1_next.v1 = q_data.d;
                s1_next.u2 = q_data.d;  s1_next.v2 = q_data.x2py;
                s1_next.u3 = q_data.b;  s1_next.v3 = q_data.xp2y;
                s1_next.t  = q_data.t_mm;
            end
            3'd3:
            begin
                s1_next.u1 = q_data.a;  s1_next.v1 = q_data.d;
                s1_next.u2 = q_data.d;  s1_next.v2 = q_data.x2my;
                s1_next.u3 = q_data.a;  s1_next.v3 = q_data.y2mx;
                s1_next.t  = q_data.t_pm;
            end
            3'd4:
            begin
                s1_next.u1 = q_data.ab; s1_next.v1 = q_data.c;
                s1_next.u2 = q_data.x;  s1_next.v2 = q_data.c;
                s1_next.u3 = q_data.ab; s1_next.v3 = q8sf_pkg::ONE_OPD;
                s1_next.t  = q8sf_pkg::ONE_OPD;
            end
            3'd5:
            begin
                s1_next.u1 = q_data.cd; s1_next.v1 = q_data.b;
                s1_next.u2 = q_data.cd; s1_next.v2 = q8sf_pkg::ONE_OPD;
                s1_next.u3 = q_data.y;  s1_next.v3 = q_data.b;
                s1_next.t  = q8sf_pkg::ONE_OPD;
            end
            3'd6:
            begin
                s1_next.u1 = q_data.ab; s1_next.v1 = q_data.d;
                s1_next.u2 = q_data.x;  s1_next.v2 = q_data.d;
                s1_next.u3 = q_data.ab; s1_next.v3 = q8sf_pkg::ONE_OPD;
                s1_next.t  = q8sf_pkg::ONE_OPD;
            end
            3'd7:
            begin
                s1_next.u1 = q_data.cd; s1_next.v1 = q_data.a;
                s1_next.u2 = q_data.cd; s1_next.v2 = q8sf_pkg::ONE_OPD;
                s1_next.u3 = q_data.y;  s1_next.v3 = q_data.a;
                s1_next.t  = q8sf_pkg::ONE_OPD;
            end
            default:
            begin
                s1_next.t = q8sf_pkg::ONE_OPD;
            end
        endcase
    end

    always_comb
    begin
        s2_next.node = s1_reg.node;
        s2_next.p    = q8sf_pkg::PROD_W'($signed(s1_reg.u1) * $signed(s1_reg.v1));
        s2_next.q    = q8sf_pkg::PROD_W'($signed(s1_reg.u2) * $signed(s1_reg.v2));
        s2_next.r    = q8sf_pkg::PROD_W'($signed(s1_reg.u3) * $signed(s1_reg.v3));
        s2_next.t    = s1_reg.t;
    end

    always_comb
    begin
        s3_next.node = s2_reg.node;
        s3_next.pv   = q8sf_pkg::PROD2_W'($signed(q8sf_pkg::fmul_round(s2_reg.p))
                                          * $signed(s2_reg.t));
        s3_next.fq   = q8sf_pkg::fmul_round(s2_reg.q);
        s3_next.fr   = q8sf_pkg::fmul_round(s2_reg.r);
    end

    // Corners: -v/4, dx/4, dy/4. Mid-sides: v/2, and derivatives that are
    // either a negated product or a halved ab or cd.
    always_comb
    begin
        ops.val = '{neg: 1'b0, shift: q8sf_pkg::SH_HALF};
        ops.dx  = '{neg: 1'b0, shift: q8sf_pkg::SH_QUARTER};
        ops.dy  = '{neg: 1'b0, shift: q8sf_pkg::SH_QUARTER};
        case (s3_reg.node)
            3'd0, 3'd1, 3'd2, 3'd3:
            begin
                ops.val = '{neg: 1'b1, shift: q8sf_pkg::SH_QUARTER};
            end
            3'd4:
            begin
                ops.dx = '{neg: 1'b1, shift: q8sf_pkg::SH_NONE};
                ops.dy = '{neg: 1'b1, shift: q8sf_pkg::SH_HALF};
            end
            3'd5:
            begin
                ops.dx = '{neg: 1'b0, shift: q8sf_pkg::SH_HALF};
                ops.dy = '{neg: 1'b1, shift: q8sf_pkg::SH_NONE};
            end
            3'd6:
            begin
                ops.dx = '{neg: 1'b1, shift: q8sf_pkg::SH_NONE};
                ops.dy = '{neg: 1'b0, shift: q8sf_pkg::SH_HALF};
            end
            3'd7:
            begin
                ops.dx = '{neg: 1'b1, shift: q8sf_pkg::SH_HALF};
                ops.dy = '{neg: 1'b1, shift: q8sf_pkg::SH_NONE};
            end
            default:
            begin
                ops.val = '{neg: 1'b0, shift: q8sf_pkg::SH_HALF};
            end
        endcase
    end

    assign val_v = q8sf_pkg::fmul2_round(s3_reg.pv);
    assign dx_v  = q8sf_pkg::VAL_W'(s3_reg.fq);
    assign dy_v  = q8sf_pkg::VAL_W'(s3_reg.fr);

    assign out_data_next = {q8sf_pkg::post_sat(dy_v, ops.dy),
                            q8sf_pkg::post_sat(dx_v, ops.dx),
                            q8sf_pkg::post_sat(val_v, ops.val)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_cnt_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            node_cnt_reg <= node_cnt_next;
            if (en)
            begin
                s1_valid_reg  <= q_valid;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg       <= s1_next;
            s2_reg       <= s2_next;
            s3_reg       <= s3_next;
            out_data_reg <= out_data_next;
            out_node_reg <= s3_reg.node;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_node_reg;
    assign m_tlast  = out_node_reg == q8sf_pkg::NODE_LAST;

endmodule

// File: src/quad8_shape_function_eval_unit.sv
// ============================================================================
// quad8_shape_function_eval_unit
// Eight-node serendipity quadrilateral shape functions and their derivatives.
//
//   Port group  Dir  Beat contents
//   s_*         in   one reference point (x_coord, y_coord), signed Q1.14
//   m_*         out  one node: index in tuser, value and dx, dy in tdata,
//                    tlast on node 7
//
// Each point gives eight output beats, one per cycle while m_tready does not stall;
// the shared per-node multiplier pipeline takes the next point after issuing node 7.
// A point passes the input register, the queue, the s1, s2, s3 and output registers.
// Reset empties the input register, the point queue and the pipeline.
// A stall on m_tready freezes the node pipeline; the queue keeps taking points
// until it fills.
// ============================================================================
module quad8_shape_function_eval_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [q8sf_pkg::S_TDATA_W-1:0]     s_tdata,   // x_coord, y_coord
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [q8sf_pkg::M_TDATA_W-1:0]     m_tdata,   // shape_value, deriv_x, deriv_y
    output logic [q8sf_pkg::NODE_W-1:0]        m_tuser,   // node_index
    output logic                               m_tlast
);

    logic              push_valid;
    logic              push_ready;
    q8sf_pkg::point_t  push_data;
    logic              q_valid;
    logic              q_ready;
    q8sf_pkg::point_t  q_data;

    q8sf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    q8sf_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (push_valid),
        .in_ready   (push_ready),
        .in_data    (push_data),
        .out_valid  (q_valid),
        .out_ready  (q_ready),
        .out_data   (q_data)
    );

    q8sf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (q_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// File: dv/q8sf_node_checker.sv
// ============================================================================
// q8sf_node_checker
// Watches both stream channels of the quad8 shape function unit. For every
// accepted point it computes the eight node beats in its own fixed-point
// model, queues them, and compares every output beat field by field.
// ============================================================================
module q8sf_node_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [q8sf_pkg::S_TDATA_W-1:0]     s_tdata,   // x_coord, y_coord
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [q8sf_pkg::M_TDATA_W-1:0]     m_tdata,   // shape_value, deriv_x, deriv_y
    input  logic [q8sf_pkg::NODE_W-1:0]        m_tuser,   // node_index
    input  logic                               m_tlast,
    output int                                 fail_count,
    output int                                 pending_count
);

    typedef struct {
        logic [q8sf_pkg::NODE_W-1:0]       node;
        logic signed [q8sf_pkg::OUT_W-1:0] value;
        logic signed [q8sf_pkg::OUT_W-1:0] dx;
        logic signed [q8sf_pkg::OUT_W-1:0] dy;
        logic                              last;
    } node_beat_t;

    node_beat_t expected_nodes[$];

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // Divide by 2^n, rounding to nearest with ties toward plus infinity.
    function automatic longint round_shift(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint qmul(input longint p, input longint q);
        return round_shift(p * q, q8sf_pkg::FRAC_BITS);
    endfunction

    function automatic logic signed [q8sf_pkg::OUT_W-1:0] clamp16(input longint v);
        if (v > 32767)
        begin
            return 16'sh7FFF;
        end
        if (v < -32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic void predict_point(input logic signed [15:0] xc,
                                          input logic signed [15:0] yc);
        longint     s;
        longint     x;
        longint     y;
        longint     a;
        longint     b;
        longint     c;
        longint     d;
        longint     ab;
        longint     cd;
        longint     val[8];
        longint     dx[8];
        longint     dy[8];
        node_beat_t beat;
        s  = 64'sd1 <<< q8sf_pkg::FRAC_BITS;
        x  = xc;
        y  = yc;
        a  = s - x;
        b  = s + x;
        c  = s - y;
        d  = s + y;
        ab = qmul(a, b);
        cd = qmul(c, d);

        val[0] = round_shift(-qmul(qmul(a, c), s + x + y), 2);
        val[1] = round_shift(-qmul(qmul(b, c), s - x + y), 2);
        val[2] = round_shift(-qmul(qmul(b, d), s - x - y), 2);
        val[3] = round_shift(-qmul(qmul(a, d), s + x - y), 2);
        val[4] = round_shift(qmul(ab, c), 1);
        val[5] = round_shift(qmul(cd, b), 1);
        val[6] = round_shift(qmul(ab, d), 1);
        val[7] = round_shift(qmul(cd, a), 1);

        dx[0] = round_shift(qmul(c, 2 * x + y), 2);
        dy[0] = round_shift(qmul(a, x + 2 * y), 2);
        dx[1] = round_shift(qmul(c, 2 * x - y), 2);
        dy[1] = round_shift(qmul(b, 2 * y - x), 2);
        dx[2] = round_shift(qmul(d, 2 * x + y), 2);
        dy[2] = round_shift(qmul(b, x + 2 * y), 2);
        dx[3] = round_shift(qmul(d, 2 * x - y), 2);
        dy[3] = round_shift(qmul(a, 2 * y - x), 2);
        dx[4] = -qmul(x, c);
        dy[4] = round_shift(-ab, 1);
        dx[5] = round_shift(cd, 1);
        dy[5] = -qmul(y, b);
        dx[6] = -qmul(x, d);
        dy[6] = round_shift(ab, 1);
        dx[7] = round_shift(-cd, 1);
        dy[7] = -qmul(y, a);

        for (int k = 0; k < 8; k++)
        begin
            beat.node  = q8sf_pkg::NODE_W'(k);
            beat.value = clamp16(val[k]);
            beat.dx    = clamp16(dx[k]);
            beat.dy    = clamp16(dy[k]);
            beat.last  = (beat.node == q8sf_pkg::NODE_LAST);
            expected_nodes.push_back(beat);
        end
    endfunction

    task automatic check_node_beat();
        node_beat_t                        exp_beat;
        logic signed [q8sf_pkg::OUT_W-1:0] got_value;
        logic signed [q8sf_pkg::OUT_W-1:0] got_dx;
        logic signed [q8sf_pkg::OUT_W-1:0] got_dy;
        got_value = m_tdata[15:0];
        got_dx    = m_tdata[31:16];
        got_dy    = m_tdata[47:32];
        if (expected_nodes.size() == 0)
        begin
            report_mismatch($sformatf("unexpected beat for node %0d", m_tuser));
            return;
        end
        exp_beat = expected_nodes.pop_front();
        if (m_tuser !== exp_beat.node)
        begin
            report_mismatch($sformatf("node_index got %0d want %0d", m_tuser, exp_beat.node));
        end
        if (got_value !== exp_beat.value)
        begin
            report_mismatch($sformatf("node %0d shape_value got %0d want %0d",
                                      exp_beat.node, got_value, exp_beat.value));
        end
        if (got_dx !== exp_beat.dx)
        begin
            report_mismatch($sformatf("node %0d deriv_x got %0d want %0d",
                                      exp_beat.node, got_dx, exp_beat.dx));
        end
        if (got_dy !== exp_beat.dy)
        begin
            report_mismatch($sformatf("node %0d deriv_y got %0d want %0d",
                                      exp_beat.node, got_dy, exp_beat.dy));
        end
        if (m_tlast !== exp_beat.last)
        begin
            report_mismatch($sformatf("node %0d last_node got %0b want %0b",
                                      exp_beat.node, m_tlast, exp_beat.last));
        end
    endtask

    // Output beats are checked before a point accepted on the same edge is
    // queued, so a beat can never be matched against its own input.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                check_node_beat();
            end
            if (s_tvalid && s_tready)
            begin
                predict_point(s_tdata[15:0], s_tdata[31:16]);
            end
            pending_count <= expected_nodes.size();
        end
    end

endmodule

// File: dv/tb_quad8_shape_function_eval_unit.sv
// ============================================================================
// tb_quad8_shape_function_eval_unit
// Drives reference points into the quad8 shape function unit: a directed set
// of corners, mid-sides, code extremes and rounding ties, then random points
// under three idling patterns. A separate checker predicts every node beat.
// ============================================================================
module tb_quad8_shape_function_eval_unit;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int PHASE_POINTS  = 85;

    logic                               clk      = 1'b0;
    logic                               rst_n    = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [q8sf_pkg::S_TDATA_W-1:0]     s_tdata  = '0;   // x_coord, y_coord
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [q8sf_pkg::M_TDATA_W-1:0]     m_tdata;         // shape_value, deriv_x, deriv_y
    logic [q8sf_pkg::NODE_W-1:0]        m_tuser;         // node_index
    logic                               m_tlast;

    int fail_count;
    int pending_count;
    int cycle_count    = 0;
    int point_gap_pct  = 30;
    int node_stall_pct = 81;

    quad8_shape_function_eval_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    q8sf_node_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= node_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Holds the point on the bus until the beat is accepted. When no gap is
    // drawn, tvalid stays high and only the data changes.
    task automatic send_point(input logic signed [15:0] xv, input logic signed [15:0] yv);
        while ($urandom_range(0, 99) < point_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {yv, xv};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random_point();
        logic signed [15:0] xv;
        logic signed [15:0] yv;
        int                 pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            // Any code at all, including points well outside the element.
            xv = 16'($urandom);
            yv = 16'($urandom);
        end
        else
        begin
            xv = 16'($urandom_range(0, 32768) - 16384);
            yv = 16'($urandom_range(0, 32768) - 16384);
        end
        send_point(xv, yv);
    endtask

    task automatic wait_for_drain();
        do
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        while (pending_count != 0);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner nodes, mid-side nodes and the element center.
        send_point(-16384, -16384);
        send_point( 16384, -16384);
        send_point( 16384,  16384);
        send_point(-16384,  16384);
        send_point(     0, -16384);
        send_point( 16384,      0);
        send_point(     0,  16384);
        send_point(-16384,      0);
        send_point(     0,      0);
        // Smallest steps and odd codes that land on rounding ties.
        send_point(     1,      1);
        send_point(    -1,     -1);
        send_point(     1,     -1);
        send_point(  8192,   8192);
        send_point( -8191,   4097);
        send_point( 16383, -16383);
        // Codes beyond the element, which drive the outputs into saturation.
        send_point(-32768, -32768);
        send_point( 32767,  32767);
        send_point(-32768,  32767);
        send_point( 32767, -32768);
        send_point(     0, -32768);
        send_point(-32768,      0);
        send_point( 21845, -21846);

        for (int i = 0; i < PHASE_POINTS; i++)
        begin
            send_random_point();
        end
        wait_for_drain();

        point_gap_pct  = 81;
        node_stall_pct = 30;
        for (int i = 0; i < PHASE_POINTS; i++)
        begin
            send_random_point();
        end
        wait_for_drain();

        point_gap_pct  = 0;
        node_stall_pct = 0;
        for (int i = 0; i < PHASE_POINTS; i++)
        begin
            send_random_point();
        end
        wait_for_drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
